### src/pfp_pkg.sv
// Package for the palette crossfade engine.
// Widths, operation and register codes, and the structs passed between modules.
// No dependencies.
package pfp_pkg;

	localparam int COLOR_W     = 32;
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 4;
	localparam int STAGE_W     = 8;
	localparam int DELAY_W     = 16;
	localparam int INDEX_W     = 8;
	localparam int OP_W        = 2;
	localparam int CNT_W       = 18;
	localparam int PROD_W      = 16;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP  = 2'd2;

	localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_SHIFT;

	typedef struct packed {
		logic wr;
		logic rd;
	} pal_ctl_t;

	typedef struct packed {
		logic [STAGE_W-1:0] shown;
		logic [STAGE_W-1:0] total;
		logic [RECIP_W-1:0] recip;
	} blend_cfg_t;

endpackage

### src/pfp_if.sv
// Channel interfaces of the palette crossfade engine: command items and result items.
// Depends on pfp_pkg for field widths.
interface pfp_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [pfp_pkg::OP_W-1:0]     operation;
	logic [pfp_pkg::INDEX_W-1:0]  entry_index;
	logic [pfp_pkg::COLOR_W-1:0]  start_color;
	logic [pfp_pkg::COLOR_W-1:0]  end_color;
	logic [pfp_pkg::DELAY_W-1:0]  time_delta;
	logic                         visible;

	modport source (output valid, operation, entry_index, start_color, end_color,
		time_delta, visible, input ready);
	modport sink (input valid, operation, entry_index, start_color, end_color,
		time_delta, visible, output ready);
endinterface

interface pfp_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pfp_pkg::COLOR_W-1:0]  blended_color;
	logic [pfp_pkg::STAGE_W-1:0]  current_stage;
	logic                         stage_stepped;
	logic                         finished;

	modport source (output valid, blended_color, current_stage, stage_stepped, finished,
		input ready);
	modport sink (input valid, blended_color, current_stage, stage_stepped, finished,
		output ready);
endinterface

### src/pfp_recip.sv
// Restoring divider producing floor(2^24 / stage total), one quotient bit a cycle.
// Depends on pfp_pkg.
module pfp_recip (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfp_pkg::STAGE_W-1:0]   divisor,
	output logic                          busy,
	output logic [pfp_pkg::RECIP_W-1:0]   recip
);

	localparam int STEP_W = $clog2(pfp_pkg::RECIP_W);
	localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(pfp_pkg::RECIP_W - 1);

	logic                          busy_q;
	logic [STEP_W-1:0]             step_q;
	logic [pfp_pkg::STAGE_W-1:0]   rem_q;
	logic [pfp_pkg::STAGE_W-1:0]   div_q;
	logic [pfp_pkg::RECIP_W-1:0]   quo_q;
	logic [pfp_pkg::STAGE_W:0]     shifted;
	logic [pfp_pkg::STAGE_W:0]     trial;
	logic                          fits;

	always_comb begin
		shifted = {rem_q, (step_q == STEP_TOP)};
		fits    = shifted >= {1'b0, div_q};
		trial   = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			div_q  <= pfp_pkg::STAGE_W'(1);
			quo_q  <= pfp_pkg::RECIP_ONE;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_TOP;
			rem_q  <= '0;
			div_q  <= divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[pfp_pkg::STAGE_W-1:0] : shifted[pfp_pkg::STAGE_W-1:0];
			quo_q <= {quo_q[pfp_pkg::RECIP_W-2:0], fits};
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	assign busy  = busy_q;
	assign recip = quo_q;

endmodule

### src/pfp_blend.sv
// Start and end palette memories and the four-lane blend pipeline.
// Blend divides by the stage total through a reciprocal multiply and one correction.
// Depends on pfp_pkg.
module pfp_blend #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pfp_pkg::pal_ctl_t                     ctl,
	input  logic [$clog2(PALETTE_ENTRIES)-1:0]    addr,
	input  logic [pfp_pkg::COLOR_W-1:0]           start_color,
	input  logic [pfp_pkg::COLOR_W-1:0]           end_color,
	input  pfp_pkg::blend_cfg_t                   cfg,
	output logic                                  done,
	output logic [pfp_pkg::COLOR_W-1:0]           blended
);

	localparam int CW   = pfp_pkg::CHAN_W;
	localparam int NC   = pfp_pkg::NUM_CHAN;
	localparam int PW   = pfp_pkg::PROD_W;
	localparam int MW   = PW + pfp_pkg::RECIP_W;
	localparam int QW   = PW + pfp_pkg::STAGE_W;
	localparam int VW   = PW + 2;

	logic [pfp_pkg::COLOR_W-1:0] start_mem [PALETTE_ENTRIES];
	logic [pfp_pkg::COLOR_W-1:0] end_mem   [PALETTE_ENTRIES];

	logic [pfp_pkg::COLOR_W-1:0] start_s1;
	logic [pfp_pkg::COLOR_W-1:0] end_s1;
	logic                        v_s1;
	logic                        v_s2;
	logic                        v_s3;
	logic                        done_q;

	logic [PW-1:0] n_s2  [NC];
	logic          neg_s2 [NC];
	logic [CW-1:0] sc_s2 [NC];
	logic [PW-1:0] qe_s3 [NC];
	logic [PW-1:0] n_s3  [NC];
	logic          neg_s3 [NC];
	logic [CW-1:0] sc_s3 [NC];
	logic [pfp_pkg::COLOR_W-1:0] blended_q;

	logic [PW-1:0] n_c   [NC];
	logic          neg_c [NC];
	logic [PW-1:0] qe_c  [NC];
	logic [CW-1:0] v_c   [NC];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			start_mem[addr] <= start_color;
			end_mem[addr]   <= end_color;
		end
		if (ctl.rd) begin
			start_s1 <= start_mem[addr];
			end_s1   <= end_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= ctl.rd;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	// magnitude of end minus start, times shown stage
	always_comb begin
		for (int ch = 0; ch < NC; ch++) begin
			logic [CW-1:0] sc;
			logic [CW-1:0] ec;
			logic [CW-1:0] mag;
			sc        = start_s1[ch*CW +: CW];
			ec        = end_s1[ch*CW +: CW];
			neg_c[ch] = ec < sc;
			mag       = neg_c[ch] ? sc - ec : ec - sc;
			n_c[ch]   = PW'(mag) * PW'(cfg.shown);
		end
	end

	// quotient estimate, low by at most one
	always_comb begin
		for (int ch = 0; ch < NC; ch++) begin
			logic [MW-1:0] prod;
			prod     = MW'(n_s2[ch]) * MW'(cfg.recip);
			qe_c[ch] = prod[pfp_pkg::RECIP_SHIFT +: PW];
		end
	end

	// correct the quotient, apply sign, add start and clamp
	always_comb begin
		for (int ch = 0; ch < NC; ch++) begin
			logic [QW-1:0]        qd;
			logic [QW-1:0]        rem;
			logic [PW-1:0]        q;
			logic signed [VW-1:0] sv;
			logic signed [VW-1:0] qs;
			logic signed [VW-1:0] v;
			qd  = QW'(qe_s3[ch]) * QW'(cfg.total);
			rem = QW'(n_s3[ch]) - qd;
			q   = (rem >= QW'(cfg.total)) ? qe_s3[ch] + PW'(1) : qe_s3[ch];
			sv  = $signed(VW'(sc_s3[ch]));
			qs  = $signed(VW'(q));
			v   = neg_s3[ch] ? sv - qs : sv + qs;
			if (v < 0) begin
				v_c[ch] = '0;
			end else if (v > $signed(VW'(255))) begin
				v_c[ch] = '1;
			end else begin
				v_c[ch] = v[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NC; ch++) begin
			n_s2[ch]   <= n_c[ch];
			neg_s2[ch] <= neg_c[ch];
			sc_s2[ch]  <= start_s1[ch*CW +: CW];
			qe_s3[ch]  <= qe_c[ch];
			n_s3[ch]   <= n_s2[ch];
			neg_s3[ch] <= neg_s2[ch];
			sc_s3[ch]  <= sc_s2[ch];
			blended_q[ch*CW +: CW] <= v_c[ch];
		end
	end

	assign done    = done_q;
	assign blended = blended_q;

endmodule

### src/palette_fade_pingpong.sv
// Top level of the palette crossfade engine: fade state, sequencing and result buffering.
// Depends on pfp_pkg, pfp_if, pfp_recip and pfp_blend.
//
// Usage: command items enter on cmd, one result item per command leaves on rsp.
// Load writes one entry of both palettes and restarts the fade; tick advances the
// countdown and stage; read blends one entry at the shown stage.
// Configuration goes through cfg_we / cfg_idx / cfg_data while the block is idle.
// One item is worked on at a time: a new command is taken only after the result of the
// last has left the result buffer. Load and tick put their result straight into the
// result buffer; read passes through the palette memory read, three blend stages, the
// result buffer, then the output register, which drives rsp.
// Writing total_stages starts the reciprocal divider: cmd.ready stays low while it is
// busy, producing one quotient bit a cycle.
// A stalled receiver holds the output register; one further finished item may wait in
// the result buffer behind it, after which cmd.ready drops.
// Reset clears the fade state, sets the stage total to one and clears the other
// configuration registers; palette contents are undefined until loaded.
module palette_fade_pingpong #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pfp_cmd_if.sink                           cmd,
	pfp_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [pfp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam int SW = pfp_pkg::STAGE_W;
	localparam int KW = pfp_pkg::CNT_W;
	localparam int XW = pfp_pkg::INDEX_W + 1;

	typedef enum logic {S_IDLE, S_BLEND} state_t;

	state_t                        state_q;
	logic                          res_valid_q;
	logic [pfp_pkg::COLOR_W-1:0]   res_color_q;
	logic [SW-1:0]                 res_stage_q;
	logic                          res_stepped_q;
	logic                          res_done_q;
	logic                          out_valid_q;
	logic [pfp_pkg::COLOR_W-1:0]   out_color_q;
	logic [SW-1:0]                 out_stage_q;
	logic                          out_stepped_q;
	logic                          out_done_q;

	logic [SW-1:0]                 total_q;
	logic [pfp_pkg::DELAY_W-1:0]   delay_q;
	logic                          loop_q;
	logic [KW-1:0]                 countdown_q;
	logic [SW-1:0]                 stage_q;
	logic                          dir_down_q;
	logic [SW-1:0]                 shown_q;
	logic                          done_q;

	logic                          accept;
	logic [SW-1:0]                 eff_total;
	logic [KW-1:0]                 cd_sub;
	logic                          expire;
	logic                          at_end;
	logic [KW-1:0]                 nxt_cd;
	logic [SW-1:0]                 nxt_stage;
	logic                          nxt_dir;
	logic [SW-1:0]                 nxt_shown;
	logic                          nxt_done;
	logic                          stepped;
	logic                          drain;

	logic                          recip_start;
	logic [SW-1:0]                 recip_div;
	logic                          recip_busy;
	logic [pfp_pkg::RECIP_W-1:0]   recip;

	pfp_pkg::pal_ctl_t             pal_ctl;
	pfp_pkg::blend_cfg_t           blend_cfg;
	logic [AW-1:0]                 pal_addr;
	logic                          blend_done;
	logic [pfp_pkg::COLOR_W-1:0]   blend_color;

	// fold the index into the palette by constant compare and subtract
	function automatic logic [AW-1:0] wrap_index(input logic [pfp_pkg::INDEX_W-1:0] idx);
		logic [XW-1:0] r;
		r = {1'b0, idx};
		for (int k = pfp_pkg::INDEX_W - 1; k >= 0; k--) begin
			if ((PALETTE_ENTRIES << k) < (1 << pfp_pkg::INDEX_W)) begin
				if (r >= XW'(PALETTE_ENTRIES << k)) begin
					r = r - XW'(PALETTE_ENTRIES << k);
				end
			end
		end
		return r[AW-1:0];
	endfunction

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE) && !res_valid_q && !recip_busy;
	assign eff_total = (total_q == '0) ? SW'(1) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= SW'(1);
			delay_q <= '0;
			loop_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				pfp_pkg::CFG_TOTAL: total_q <= cfg_data[SW-1:0];
				pfp_pkg::CFG_DELAY: delay_q <= cfg_data[pfp_pkg::DELAY_W-1:0];
				pfp_pkg::CFG_LOOP:  loop_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign recip_start = cfg_we && (cfg_idx == pfp_pkg::CFG_TOTAL);
	assign recip_div   = (cfg_data[SW-1:0] == '0) ? SW'(1) : cfg_data[SW-1:0];

	pfp_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (recip_start),
		.divisor (recip_div),
		.busy    (recip_busy),
		.recip   (recip)
	);

	always_comb begin
		cd_sub    = countdown_q - KW'(cmd.time_delta);
		expire    = cd_sub[KW-1] || (cd_sub == '0);
		at_end    = dir_down_q ?
			((stage_q == '0) || ({1'b0, stage_q} > ({1'b0, eff_total} + (SW+1)'(1)))) :
			(stage_q >= eff_total);
		nxt_cd    = countdown_q;
		nxt_stage = stage_q;
		nxt_dir   = dir_down_q;
		nxt_shown = shown_q;
		nxt_done  = done_q;
		stepped   = 1'b0;
		case (cmd.operation)
			pfp_pkg::OP_LOAD: begin
				nxt_cd    = KW'(delay_q);
				nxt_stage = '0;
				nxt_dir   = 1'b0;
				nxt_shown = '0;
				nxt_done  = 1'b0;
			end
			pfp_pkg::OP_TICK: begin
				if (!done_q) begin
					if (expire) begin
						nxt_cd = KW'(delay_q);
						if (at_end) begin
							if (loop_q) begin
								nxt_dir = !dir_down_q;
								stepped = 1'b1;
							end else begin
								nxt_done = 1'b1;
							end
						end else begin
							nxt_stage = dir_down_q ? stage_q - SW'(1) : stage_q + SW'(1);
							stepped   = 1'b1;
						end
						if (stepped && cmd.visible) begin
							nxt_shown = nxt_stage;
						end
					end else begin
						nxt_cd = cd_sub;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			stage_q     <= '0;
			dir_down_q  <= 1'b0;
			shown_q     <= '0;
			done_q      <= 1'b0;
		end else if (accept) begin
			countdown_q <= nxt_cd;
			stage_q     <= nxt_stage;
			dir_down_q  <= nxt_dir;
			shown_q     <= nxt_shown;
			done_q      <= nxt_done;
		end
	end

	assign pal_addr        = wrap_index(cmd.entry_index);
	assign pal_ctl.wr      = accept && (cmd.operation == pfp_pkg::OP_LOAD);
	assign pal_ctl.rd      = accept && (cmd.operation == pfp_pkg::OP_READ);
	assign blend_cfg.shown = shown_q;
	assign blend_cfg.total = eff_total;
	assign blend_cfg.recip = recip;

	pfp_blend #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pal_ctl),
		.addr        (pal_addr),
		.start_color (cmd.start_color),
		.end_color   (cmd.end_color),
		.cfg         (blend_cfg),
		.done        (blend_done),
		.blended     (blend_color)
	);

	assign drain = res_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			res_valid_q   <= 1'b0;
			res_color_q   <= '0;
			res_stage_q   <= '0;
			res_stepped_q <= 1'b0;
			res_done_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_color_q   <= '0;
			out_stage_q   <= '0;
			out_stepped_q <= 1'b0;
			out_done_q    <= 1'b0;
		end else begin
			if (drain) begin
				out_valid_q   <= 1'b1;
				out_color_q   <= res_color_q;
				out_stage_q   <= res_stage_q;
				out_stepped_q <= res_stepped_q;
				out_done_q    <= res_done_q;
				res_valid_q   <= 1'b0;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.operation == pfp_pkg::OP_READ) begin
							state_q <= S_BLEND;
						end else begin
							res_valid_q   <= 1'b1;
							res_color_q   <= '0;
							res_stage_q   <= nxt_stage;
							res_stepped_q <= stepped;
							res_done_q    <= nxt_done;
						end
					end
				end
				S_BLEND: begin
					if (blend_done) begin
						res_valid_q   <= 1'b1;
						res_color_q   <= blend_color;
						res_stage_q   <= stage_q;
						res_stepped_q <= 1'b0;
						res_done_q    <= done_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.blended_color = out_color_q;
	assign rsp.current_stage = out_stage_q;
	assign rsp.stage_stepped = out_stepped_q;
	assign rsp.finished      = out_done_q;

endmodule

### src/pfp_checker.sv
// Port-level checks for the palette crossfade engine, bound to the top level.
// Depends on pfp_pkg and palette_fade_pingpong.
module pfp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  logic                              cmd_ready,
	input  logic                              rsp_valid,
	input  logic                              rsp_ready,
	input  logic [pfp_pkg::COLOR_W-1:0]       rsp_color,
	input  logic [pfp_pkg::STAGE_W-1:0]       rsp_stage,
	input  logic                              rsp_stepped,
	input  logic                              rsp_finished,
	input  logic                              cfg_we,
	input  logic [pfp_pkg::CFG_IDX_W-1:0]     cfg_idx
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_color) && $stable(rsp_stage)
			&& $stable(rsp_stepped) && $stable(rsp_finished))
		else $error("result item changed while stalled");

	a_step_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stepped |-> (rsp_color == '0) && !rsp_finished)
		else $error("stepped result carries colour or finish");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second item taken while one is in progress");

	a_recip_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx == pfp_pkg::CFG_TOTAL) |=> !cmd_ready)
		else $error("item taken while reciprocal is recomputed");

endmodule

bind palette_fade_pingpong pfp_checker u_pfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_color    (rsp.blended_color),
	.rsp_stage    (rsp.current_stage),
	.rsp_stepped  (rsp.stage_stepped),
	.rsp_finished (rsp.finished),
	.cfg_we       (cfg_we),
	.cfg_idx      (cfg_idx)
);
